// ----- hdl/i2cm_pkg.sv -----
// Shared types and constants for the I2C EEPROM byte master.
package i2cm_pkg;

    localparam int DEV_ADDR_W  = 7;
    localparam int PHASE_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int BIT_CNT_W   = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET    = 7'h50;
    localparam logic [PHASE_W-1:0]    PHASE_TICKS_RESET = 16'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_TICKS    = 2'd1;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] STAGE_DEV  = 2'd0;
    localparam logic [1:0] STAGE_WORD = 2'd1;
    localparam logic [1:0] STAGE_DATA = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_START_HI = 4'd1,
        ST_START_LO = 4'd2,
        ST_TX_LO    = 4'd3,
        ST_TX_HI    = 4'd4,
        ST_ACK_LO   = 4'd5,
        ST_ACK_HI   = 4'd6,
        ST_RX_LO    = 4'd7,
        ST_RX_HI    = 4'd8,
        ST_MACK_LO  = 4'd9,
        ST_MACK_HI  = 4'd10,
        ST_STOP_LO  = 4'd11,
        ST_STOP_MID = 4'd12,
        ST_STOP_HI  = 4'd13
    } seq_state_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [BYTE_W-1:0] word_addr;
        logic [BYTE_W-1:0] write_data;
        logic              sda_in;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              success;
        logic              done_res;
        logic              busy_res;
        logic              sda_out;
        logic              scl_out;
    } res_t;

endpackage

// ----- hdl/i2cm_seq.sv -----
// Bus sequencer: state registers, next-state logic and line decode.
module i2cm_seq
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  i2cm_pkg::req_t                       req,
    input  logic [i2cm_pkg::DEV_ADDR_W-1:0]      device_address,
    input  logic [i2cm_pkg::PHASE_W-1:0]         phase_ticks,
    output i2cm_pkg::res_t                       res
);

    i2cm_pkg::seq_state_t                 state_reg, state_next;
    logic [i2cm_pkg::PHASE_W-1:0]         phase_cnt_reg, phase_cnt_next;
    logic [i2cm_pkg::BIT_CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [i2cm_pkg::BYTE_W-1:0]          shift_reg, shift_next;
    logic [i2cm_pkg::BYTE_W-1:0]          word_addr_reg, word_addr_next;
    logic [i2cm_pkg::BYTE_W-1:0]          write_data_reg, write_data_next;
    logic                                 is_read_reg, is_read_next;
    logic [i2cm_pkg::BYTE_W-1:0]          rx_byte_reg, rx_byte_next;
    logic [1:0]                           stage_reg, stage_next;
    logic                                 pass_reg, pass_next;
    logic                                 done_c;

    logic [i2cm_pkg::PHASE_W-1:0]         limit;
    logic                                 phase_end;
    logic [i2cm_pkg::BIT_CNT_W-1:0]       bit_inc;
    logic                                 ack_checked;

    assign limit       = (phase_ticks == '0) ? i2cm_pkg::PHASE_W'(1) : phase_ticks;
    assign phase_end   = ({1'b0, phase_cnt_reg} + (i2cm_pkg::PHASE_W+1)'(1))
                         >= {1'b0, limit};
    assign bit_inc     = bit_cnt_reg + i2cm_pkg::BIT_CNT_W'(1);
    assign ack_checked = !(is_read_reg && (stage_reg == i2cm_pkg::STAGE_WORD));

    always_comb
    begin
        state_next      = state_reg;
        phase_cnt_next  = phase_cnt_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        word_addr_next  = word_addr_reg;
        write_data_next = write_data_reg;
        is_read_next    = is_read_reg;
        rx_byte_next    = rx_byte_reg;
        stage_next      = stage_reg;
        pass_next       = pass_reg;
        done_c          = 1'b0;

        if (state_reg == i2cm_pkg::ST_IDLE)
        begin
            if (req.mode == i2cm_pkg::MODE_WRITE || req.mode == i2cm_pkg::MODE_READ)
            begin
                word_addr_next  = req.word_addr;
                write_data_next = req.write_data;
                is_read_next    = (req.mode == i2cm_pkg::MODE_READ);
                stage_next      = i2cm_pkg::STAGE_DEV;
                pass_next       = 1'b1;
                phase_cnt_next  = '0;
                bit_cnt_next    = '0;
                state_next      = i2cm_pkg::ST_START_HI;
            end
        end
        else if (phase_end)
        begin
            phase_cnt_next = '0;
            case (state_reg)
                i2cm_pkg::ST_START_HI:
                    state_next = i2cm_pkg::ST_START_LO;
                i2cm_pkg::ST_START_LO:
                begin
                    shift_next   = {device_address, (stage_reg == i2cm_pkg::STAGE_DATA)};
                    bit_cnt_next = '0;
                    state_next   = i2cm_pkg::ST_TX_LO;
                end
                i2cm_pkg::ST_TX_LO:
                    state_next = i2cm_pkg::ST_TX_HI;
                i2cm_pkg::ST_TX_HI:
                begin
                    shift_next = {shift_reg[i2cm_pkg::BYTE_W-2:0], 1'b0};
                    if (bit_inc >= i2cm_pkg::BIT_CNT_W'(i2cm_pkg::BYTE_W))
                    begin
                        bit_cnt_next = '0;
                        state_next   = i2cm_pkg::ST_ACK_LO;
                    end
                    else
                    begin
                        bit_cnt_next = bit_inc;
                        state_next   = i2cm_pkg::ST_TX_LO;
                    end
                end
                i2cm_pkg::ST_ACK_LO:
                    state_next = i2cm_pkg::ST_ACK_HI;
                i2cm_pkg::ST_ACK_HI:
                begin
                    if (ack_checked && req.sda_in)
                    begin
                        pass_next  = 1'b0;
                        state_next = i2cm_pkg::ST_STOP_LO;
                    end
                    else if (stage_reg == i2cm_pkg::STAGE_DEV)
                    begin
                        stage_next   = i2cm_pkg::STAGE_WORD;
                        shift_next   = word_addr_reg;
                        bit_cnt_next = '0;
                        state_next   = i2cm_pkg::ST_TX_LO;
                    end
                    else if (stage_reg == i2cm_pkg::STAGE_WORD)
                    begin
                        stage_next = i2cm_pkg::STAGE_DATA;
                        if (is_read_reg)
                        begin
                            state_next = i2cm_pkg::ST_START_HI;
                        end
                        else
                        begin
                            shift_next   = write_data_reg;
                            bit_cnt_next = '0;
                            state_next   = i2cm_pkg::ST_TX_LO;
                        end
                    end
                    else if (is_read_reg)
                    begin
                        rx_byte_next = '0;
                        bit_cnt_next = '0;
                        state_next   = i2cm_pkg::ST_RX_LO;
                    end
                    else
                    begin
                        pass_next  = 1'b1;
                        state_next = i2cm_pkg::ST_STOP_LO;
                    end
                end
                i2cm_pkg::ST_RX_LO:
                    state_next = i2cm_pkg::ST_RX_HI;
                i2cm_pkg::ST_RX_HI:
                begin
                    rx_byte_next = {rx_byte_reg[i2cm_pkg::BYTE_W-2:0], req.sda_in};
                    if (bit_inc >= i2cm_pkg::BIT_CNT_W'(i2cm_pkg::BYTE_W))
                    begin
                        bit_cnt_next = '0;
                        state_next   = i2cm_pkg::ST_MACK_LO;
                    end
                    else
                    begin
                        bit_cnt_next = bit_inc;
                        state_next   = i2cm_pkg::ST_RX_LO;
                    end
                end
                i2cm_pkg::ST_MACK_LO:
                    state_next = i2cm_pkg::ST_MACK_HI;
                i2cm_pkg::ST_MACK_HI:
                begin
                    pass_next  = 1'b1;
                    state_next = i2cm_pkg::ST_STOP_LO;
                end
                i2cm_pkg::ST_STOP_LO:
                    state_next = i2cm_pkg::ST_STOP_MID;
                i2cm_pkg::ST_STOP_MID:
                    state_next = i2cm_pkg::ST_STOP_HI;
                i2cm_pkg::ST_STOP_HI:
                begin
                    state_next = i2cm_pkg::ST_IDLE;
                    done_c     = 1'b1;
                end
                default:
                    state_next = i2cm_pkg::ST_IDLE;
            endcase
        end
        else
        begin
            phase_cnt_next = phase_cnt_reg + i2cm_pkg::PHASE_W'(1);
        end
    end

    always_comb
    begin
        res.scl_out   = 1'b1;
        res.sda_out   = 1'b1;
        res.busy_res  = (state_next != i2cm_pkg::ST_IDLE);
        res.done_res  = done_c;
        res.success   = done_c && pass_next;
        res.read_data = (done_c && pass_next && is_read_next) ? rx_byte_next : '0;
        case (state_next)
            i2cm_pkg::ST_START_LO:
                res.sda_out = 1'b0;
            i2cm_pkg::ST_TX_LO:
            begin
                res.scl_out = 1'b0;
                res.sda_out = shift_next[i2cm_pkg::BYTE_W-1];
            end
            i2cm_pkg::ST_TX_HI:
                res.sda_out = shift_next[i2cm_pkg::BYTE_W-1];
            i2cm_pkg::ST_ACK_LO, i2cm_pkg::ST_RX_LO, i2cm_pkg::ST_MACK_LO:
                res.scl_out = 1'b0;
            i2cm_pkg::ST_STOP_LO:
            begin
                res.scl_out = 1'b0;
                res.sda_out = 1'b0;
            end
            i2cm_pkg::ST_STOP_MID:
                res.sda_out = 1'b0;
            default:
            begin
                res.scl_out = 1'b1;
                res.sda_out = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= i2cm_pkg::ST_IDLE;
            phase_cnt_reg  <= '0;
            bit_cnt_reg    <= '0;
            shift_reg      <= '0;
            word_addr_reg  <= '0;
            write_data_reg <= '0;
            is_read_reg    <= 1'b0;
            rx_byte_reg    <= '0;
            stage_reg      <= i2cm_pkg::STAGE_DEV;
            pass_reg       <= 1'b0;
        end
        else if (step)
        begin
            state_reg      <= state_next;
            phase_cnt_reg  <= phase_cnt_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            word_addr_reg  <= word_addr_next;
            write_data_reg <= write_data_next;
            is_read_reg    <= is_read_next;
            rx_byte_reg    <= rx_byte_next;
            stage_reg      <= stage_next;
            pass_reg       <= pass_next;
        end
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.done_res |-> !res.busy_res)
        else $error("done reported while sequencer stays busy");

    a_rdata_only_on_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (res.read_data != '0) |-> (res.done_res && res.success))
        else $error("read data shown outside a successful finish");

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(state_reg) && $stable(phase_cnt_reg)))
        else $error("sequencer advanced without a request");

    a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg < i2cm_pkg::BIT_CNT_W'(i2cm_pkg::BYTE_W))
        else $error("bit counter out of range");
`endif

endmodule

// ----- hdl/i2c_eeprom_byte_master.sv -----
// Top level of the I2C EEPROM byte master: ports, config, request and result registers.
//
//   channel  | dir | handshake         | contents
//   s_*      | in  | s_tvalid/s_tready | one bus tick request
//   m_*      | out | m_tvalid/m_tready | line levels and status after the tick
//   cfg_*    | in  | cfg_we            | device address, phase ticks
//
// One request per clock is taken unless the result register stalls.
// The request register and the result register are the only pipeline stages;
// the sequencer state advances when the request register moves to the result register.
// A stalled result register holds the request register, which in turn drops s_tready.
// Reset clears valid flags and sequencer state; request and result data are not reset.
module i2c_eeprom_byte_master
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [23:0]                           s_tdata,  // word_addr, write_data, sda_in
    input  logic [1:0]                            s_tuser,  // mode
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // scl_out, sda_out, busy_res, done_res, success, read_data
    output logic [15:0]                           m_tdata,
    input  logic                                  cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic                                 in_valid_reg;
    i2cm_pkg::req_t                       in_req_reg;
    logic                                 out_valid_reg;
    i2cm_pkg::res_t                       out_res_reg;
    logic [i2cm_pkg::DEV_ADDR_W-1:0]      dev_addr_reg;
    logic [i2cm_pkg::PHASE_W-1:0]         phase_ticks_reg;
    logic                                 advance;
    i2cm_pkg::res_t                       seq_res;
    i2cm_pkg::req_t                       s_req;

    assign s_req.mode       = s_tuser;
    assign s_req.word_addr  = s_tdata[7:0];
    assign s_req.write_data = s_tdata[15:8];
    assign s_req.sda_in     = s_tdata[16];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg.read_data, out_res_reg.success,
                       out_res_reg.done_res, out_res_reg.busy_res,
                       out_res_reg.sda_out, out_res_reg.scl_out};

    i2cm_seq u_seq
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .req            (in_req_reg),
        .device_address (dev_addr_reg),
        .phase_ticks    (phase_ticks_reg),
        .res            (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg    <= i2cm_pkg::DEV_ADDR_RESET;
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cm_pkg::CFG_DEVICE_ADDRESS:
                    dev_addr_reg <= cfg_data[i2cm_pkg::DEV_ADDR_W-1:0];
                i2cm_pkg::CFG_PHASE_TICKS:
                    phase_ticks_reg <= cfg_data[i2cm_pkg::PHASE_W-1:0];
                default:
                begin
                    dev_addr_reg    <= dev_addr_reg;
                    phase_ticks_reg <= phase_ticks_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg <= s_req;
        end
        if (advance)
        begin
            out_res_reg <= seq_res;
        end
    end

endmodule
